/* design/gtpc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtpc_pkg
// shared types, control word layout and microcode rom of the turn controller
// ----------------------------------------------------------------------------
package gtpc_pkg;

   // datapath operation selected by one control word
   typedef enum logic [2:0] {
      OP_NOP,
      OP_ERR,
      OP_INIT,
      OP_DIV,
      OP_SQ,
      OP_MUL,
      OP_FIN
   } op_type;

   // sequencing of the step counter
   typedef enum logic [1:0] {
      JMP_NEXT,
      JMP_LOOP,
      JMP_END
   } jmp_type;

   typedef enum logic [1:0] {
      PH_RUNNING,
      PH_SETTLING,
      PH_DONE
   } phase_type;

   typedef enum logic [2:0] {
      CSR_TARGET,
      CSR_TOP_SPEED,
      CSR_MIN_DRIVE,
      CSR_RAMP_SPAN,
      CSR_THRESHOLD
   } csr_index_type;

   typedef logic [2:0] step_type;

   localparam step_type STEP_ERR  = 3'd0;
   localparam step_type STEP_INIT = 3'd1;
   localparam step_type STEP_DIV  = 3'd2;
   localparam step_type STEP_SQ   = 3'd3;
   localparam step_type STEP_MUL  = 3'd4;
   localparam step_type STEP_FIN  = 3'd5;

   // quotient bits of the normalized error, one per divide step
   localparam logic [3:0] DIV_STEPS = 4'd15;
   localparam logic [15:0] ONE_Q15 = 16'h8000;
   localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

   typedef struct packed {
      op_type   op;
      jmp_type  jmp;
      step_type tgt;
   } ucode_type;

   typedef struct packed {
      logic   en;
      op_type op;
   } dp_ctrl_type;

   typedef struct packed {
      logic signed [23:0] target;
      logic [7:0]         top_speed;
      logic [7:0]         min_drive;
      logic [22:0]        ramp_span;
      logic [15:0]        threshold;
   } cfg_type;

   typedef struct packed {
      logic       div_last;
      logic       below;
      logic       err_zero;
      logic       diff_neg;
      logic [7:0] drive;
   } dp_status_type;

   function automatic ucode_type ucode_rom(input step_type s);
      ucode_type w;
      case (s)
         STEP_ERR:  w = '{op: OP_ERR,  jmp: JMP_NEXT, tgt: STEP_ERR};
         STEP_INIT: w = '{op: OP_INIT, jmp: JMP_NEXT, tgt: STEP_ERR};
         STEP_DIV:  w = '{op: OP_DIV,  jmp: JMP_LOOP, tgt: STEP_DIV};
         STEP_SQ:   w = '{op: OP_SQ,   jmp: JMP_NEXT, tgt: STEP_ERR};
         STEP_MUL:  w = '{op: OP_MUL,  jmp: JMP_NEXT, tgt: STEP_ERR};
         STEP_FIN:  w = '{op: OP_FIN,  jmp: JMP_END,  tgt: STEP_ERR};
         default:   w = '{op: OP_NOP,  jmp: JMP_END,  tgt: STEP_ERR};
      endcase
      return w;
   endfunction

endpackage

/* design/gtpc_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtpc_datapath
// error, restoring divide, square and scale registers driven by the microcode
// ----------------------------------------------------------------------------
module gtpc_datapath
   import gtpc_pkg::*;
(
   input  logic               clock,
   input  dp_ctrl_type        ctrl,
   input  cfg_type            cfg,
   input  logic signed [23:0] rotation,
   output dp_status_type      status
);

   logic [24:0] err_ff, err_in;
   logic        neg_ff, neg_in;
   logic        clamp_ff, clamp_in;
   logic [22:0] rem_ff, rem_in;
   logic [14:0] quot_ff, quot_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        below_ff, below_in;
   logic [30:0] sq_ff, sq_in;
   logic [7:0]  drive_ff, drive_in;

   logic signed [24:0] diff;
   logic [22:0] span_eff;
   logic [23:0] shifted;
   logic [15:0] e_val;
   logic [15:0] d_val;
   logic [31:0] sq_full;
   logic [30:0] num;
   logic [38:0] prod;

   always_comb begin
      diff     = 25'(cfg.target) - 25'(rotation);
      span_eff = (cfg.ramp_span == '0) ? 23'd1 : cfg.ramp_span;
      shifted  = {rem_ff, 1'b0};
      e_val    = clamp_ff ? ONE_Q15 : {1'b0, quot_ff};
      d_val    = ONE_Q15 - e_val;
      sq_full  = d_val * d_val;
      num      = ONE_Q30 - sq_ff;
      prod     = num * cfg.top_speed;

      err_in   = err_ff;
      neg_in   = neg_ff;
      clamp_in = clamp_ff;
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      cnt_in   = cnt_ff;
      below_in = below_ff;
      sq_in    = sq_ff;
      drive_in = drive_ff;

      if (ctrl.en) begin
         case (ctrl.op)
            OP_ERR: begin
               neg_in = diff[24];
               err_in = diff[24] ? 25'(-diff) : 25'(diff);
            end
            OP_INIT: begin
               // at or beyond the span the normalized error saturates at one
               clamp_in = err_ff >= {2'b00, span_eff};
               rem_in   = err_ff[22:0];
               quot_in  = '0;
               cnt_in   = DIV_STEPS;
            end
            OP_DIV: begin
               if (shifted >= {1'b0, span_eff}) begin
                  rem_in  = 23'(shifted - {1'b0, span_eff});
                  quot_in = {quot_ff[13:0], 1'b1};
               end else begin
                  rem_in  = shifted[22:0];
                  quot_in = {quot_ff[13:0], 1'b0};
               end
               cnt_in = cnt_ff - 4'd1;
            end
            OP_SQ: begin
               below_in = e_val < cfg.threshold;
               sq_in    = sq_full[30:0];
            end
            OP_MUL: begin
               drive_in = prod[37:30];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      err_ff   <= err_in;
      neg_ff   <= neg_in;
      clamp_ff <= clamp_in;
      rem_ff   <= rem_in;
      quot_ff  <= quot_in;
      cnt_ff   <= cnt_in;
      below_ff <= below_in;
      sq_ff    <= sq_in;
      drive_ff <= drive_in;
   end

   always_comb begin
      status.div_last = cnt_ff == 4'd1;
      status.below    = below_ff;
      status.err_zero = err_ff == '0;
      status.diff_neg = neg_ff;
      status.drive    = (drive_ff < cfg.min_drive) ? cfg.min_drive : drive_ff;
   end

endmodule

/* design/gyro_turn_profile_controller.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gyro_turn_profile_controller
// heading error to wheel drive with quadratic ease-out and settle detection
// ----------------------------------------------------------------------------
// channel  dir  handshake             payload
// req      in   req_tvalid/tready     rotation (24 bit signed)
// rsp      out  rsp_tvalid/tready     drives, directions, done
// csr      in   csr_valid/csr_ready   register index and write data
//
// a result is registered after error, divide setup, 15 quotient steps of the
// restoring divider (one bit per cycle), square, scale and finish; a new
// transaction is taken only once the sequencer has left its finish step, so
// items do not overlap; most steps of an item lie in the divide loop of the microcode
// the result sits in an output register; a new transaction is taken while it waits
// a full output register that is not being read holds the sequencer at its finish step
// reset is synchronous: configuration registers back to defaults, phase running, count zero
// ----------------------------------------------------------------------------
module gyro_turn_profile_controller
   import gtpc_pkg::*;
#(
   parameter int SETTLE_TICKS = 200
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [23:0] rotation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] left_drive, [8] left_reverse,
                                    // [16:9] right_drive, [17] right_reverse,
                                    // [18] done_res, [23:19] zero
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_data
);

   localparam logic [7:0] SettleTicks = 8'(SETTLE_TICKS);

   // configuration registers
   cfg_type cfg_ff, cfg_in;

   // sequencer
   logic      busy_ff, busy_in;
   step_type  step_ff, step_in;
   ucode_type cw;
   logic      req_fire, stall, advance, fin_fire;

   logic signed [23:0] rot_ff;

   dp_ctrl_type   dp_ctrl;
   dp_status_type dp_status;

   // turn state
   phase_type  phase_ff, phase_in;
   logic [7:0] settle_cnt_ff, settle_cnt_in;
   logic [7:0] cnt_inc;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [23:0] rsp_data_ff, rsp_data_in;
   logic [7:0]  ld, rd;
   logic        lr, rr, dn;

   // ---------------- configuration writes
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_TARGET:    cfg_in.target    = signed'(csr_data);
            CSR_TOP_SPEED: cfg_in.top_speed = csr_data[7:0];
            CSR_MIN_DRIVE: cfg_in.min_drive = csr_data[7:0];
            CSR_RAMP_SPAN: cfg_in.ramp_span = csr_data[22:0];
            CSR_THRESHOLD: cfg_in.threshold = csr_data[15:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target    <= '0;
         cfg_ff.top_speed <= 8'd150;
         cfg_ff.min_drive <= 8'd20;
         cfg_ff.ramp_span <= 23'd23040;
         cfg_ff.threshold <= 16'd655;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---------------- microcode sequencer
   assign req_tready = !busy_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign cw         = ucode_rom(step_ff);
   // finish waits until the output register can take the result
   assign stall      = (cw.op == OP_FIN) && rsp_valid_ff && !rsp_tready;
   assign advance    = busy_ff && !stall;
   assign fin_fire   = advance && (cw.op == OP_FIN);

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      if (req_fire) begin
         busy_in = 1'b1;
         step_in = STEP_ERR;
      end else if (advance) begin
         case (cw.jmp)
            JMP_NEXT: step_in = step_ff + 3'd1;
            JMP_LOOP: step_in = dp_status.div_last ? step_ff + 3'd1 : cw.tgt;
            JMP_END: begin
               step_in = STEP_ERR;
               busy_in = 1'b0;
            end
            default: begin
               step_in = STEP_ERR;
               busy_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= STEP_ERR;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   // input sample capture, stable for the whole item
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rot_ff <= signed'(req_tdata);
      end
   end

   assign dp_ctrl.en = advance;
   assign dp_ctrl.op = cw.op;

   gtpc_datapath u_datapath (
      .clock    (clock),
      .ctrl     (dp_ctrl),
      .cfg      (cfg_ff),
      .rotation (rot_ff),
      .status   (dp_status)
   );

   // ---------------- turn phase and result
   always_comb begin
      phase_in      = phase_ff;
      settle_cnt_in = settle_cnt_ff;
      cnt_inc       = settle_cnt_ff + 8'd1;
      ld = '0;
      rd = '0;
      lr = 1'b0;
      rr = 1'b0;
      dn = 1'b0;

      case (phase_ff)
         PH_DONE: begin
            dn = 1'b1;
         end
         PH_SETTLING: begin
            if (cnt_inc < SettleTicks) begin
               settle_cnt_in = cnt_inc;
            end else begin
               // last settle sample decides
               settle_cnt_in = '0;
               if (dp_status.below) begin
                  phase_in = PH_DONE;
                  dn       = 1'b1;
               end else begin
                  phase_in = PH_RUNNING;
                  if (!dp_status.err_zero) begin
                     ld = dp_status.drive;
                     rd = dp_status.drive;
                     lr = !dp_status.diff_neg;
                     rr = dp_status.diff_neg;
                  end
               end
            end
         end
         PH_RUNNING: begin
            if (dp_status.below) begin
               phase_in      = PH_SETTLING;
               settle_cnt_in = '0;
            end else if (!dp_status.err_zero) begin
               // target ahead: left wheel backward, right forward
               ld = dp_status.drive;
               rd = dp_status.drive;
               lr = !dp_status.diff_neg;
               rr = dp_status.diff_neg;
            end
         end
         default: begin
            phase_in = PH_RUNNING;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_RUNNING;
         settle_cnt_ff <= '0;
      end else if (fin_fire) begin
         phase_ff      <= phase_in;
         settle_cnt_ff <= settle_cnt_in;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (fin_fire) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {5'b0_0000, dn, rr, rd, lr, ld};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   // an idle sequencer always rests at its first step
   a_idle_step: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> step_ff == STEP_ERR)
      else $error("sequencer idle away from first step");

   // once done has latched every result reports done
   a_done_res: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (phase_ff == PH_DONE) |-> rsp_tdata[18])
      else $error("result without done after done latched");

   // a turning drive always has exactly one wheel reversed
   a_dir: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[7:0] != 8'd0) |-> $onehot({rsp_tdata[8], rsp_tdata[17]}))
      else $error("turning drive with bad directions");

   // settle count never reaches the settle length
   a_settle_cnt: assert property (@(posedge clock) disable iff (reset)
      settle_cnt_ff < SettleTicks)
      else $error("settle count out of range");
`endif

endmodule
